[rtl/core/lbg_pkg.sv]
// Shared types, constants and the arctangent table for the beam-to-cell projector.
package lbg_pkg;

  // Map and scan limits
  localparam int unsigned MAX_GRID_DIM = 4096;
  localparam int unsigned MAX_BEAMS    = 4096;

  // Angle and rotation constants, Q4.30 in 34-bit signed words
  localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [33:0] Q30_TWO_PI  = 34'sd6746518852;
  localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [33:0] Q30_GAIN    = 34'sd652032874;

  typedef enum logic [7:0] {
    REG_RANGE_WINDOW = 8'd0,
    REG_ANGLE_START  = 8'd1,
    REG_ANGLE_STEP   = 8'd2,
    REG_GRID_WIDTH   = 8'd3,
    REG_GRID_HEIGHT  = 8'd4,
    REG_ROW_X_GAINS  = 8'd5,
    REG_ROW_Y_GAINS  = 8'd6,
    REG_CELL_OFFSETS = 8'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0]        win_min;
    logic [31:0]        win_max;
    logic [31:0]        angle_start;
    logic [31:0]        angle_step;
    logic [12:0]        grid_w;
    logic [12:0]        grid_h;
    logic signed [31:0] gain_x0;
    logic signed [31:0] gain_x1;
    logic signed [31:0] gain_y0;
    logic signed [31:0] gain_y1;
    logic signed [31:0] off_x;
    logic signed [31:0] off_y;
  } cfg_t;

  typedef struct packed {
    logic        range_valid;
    logic [31:0] beam_range;
    logic [11:0] beam_index;
  } beam_t;

  // Item state handed from cell to cell along the rotation chain
  typedef struct packed {
    logic               rej;
    logic               flip;
    logic [31:0]        rng;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } rot_t;

  typedef struct packed {
    logic        hit;
    logic [11:0] cell_x;
    logic [11:0] cell_y;
    logic [23:0] cell_index;
  } cell_t;

  function automatic logic signed [33:0] atan_q30(input int unsigned i);
    logic signed [33:0] a;
    unique case (i)
      0:  a = 34'sh03243F6A8;
      1:  a = 34'sh01DAC6705;
      2:  a = 34'sh00FADBAFC;
      3:  a = 34'sh007F56EA6;
      4:  a = 34'sh003FEAB76;
      5:  a = 34'sh001FFD55B;
      6:  a = 34'sh000FFFAAA;
      7:  a = 34'sh0007FFF55;
      8:  a = 34'sh0003FFFEA;
      9:  a = 34'sh0001FFFFD;
      10: a = 34'sh0000FFFFF;
      11: a = 34'sh00007FFFF;
      12: a = 34'sh00003FFFF;
      13: a = 34'sh00001FFFF;
      14: a = 34'sh00000FFFF;
      15: a = 34'sh000007FFF;
      16: a = 34'sh000003FFF;
      17: a = 34'sh000001FFF;
      18: a = 34'sh000000FFF;
      19: a = 34'sh0000007FF;
      20: a = 34'sh0000003FF;
      21: a = 34'sh0000001FF;
      22: a = 34'sh0000000FF;
      23: a = 34'sh00000007F;
      24: a = 34'sh00000003F;
      25: a = 34'sh00000001F;
      26: a = 34'sh00000000F;
      27: a = 34'sh000000008;
      28: a = 34'sh000000004;
      29: a = 34'sh000000002;
      30: a = 34'sh000000001;
      default: a = 34'sh000000000;
    endcase
    return a;
  endfunction

endpackage

[rtl/core/lbg_chan_if.sv]
// Channel interfaces: beam input, cell result and configuration write.
interface lbg_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] beam_index;
  logic [31:0] beam_range;
  logic        range_valid;
  modport source (output valid, beam_index, beam_range, range_valid, input ready);
  modport sink   (input valid, beam_index, beam_range, range_valid, output ready);
endinterface

interface lbg_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [11:0] cell_x;
  logic [11:0] cell_y;
  logic [23:0] cell_index;
  modport source (output valid, hit, cell_x, cell_y, cell_index, input ready);
  modport sink   (input valid, hit, cell_x, cell_y, cell_index, output ready);
endinterface

interface lbg_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/lbg_cordic_cell.sv]
// One rotation-mode CORDIC cell with its own pipeline register.
module lbg_cordic_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          v_in,
  input  lbg_pkg::rot_t d_in,
  output logic          rdy_up,
  output logic          v_out,
  output lbg_pkg::rot_t d_out,
  input  logic          rdy_dn
);
  import lbg_pkg::*;

  logic               v_r;
  rot_t               d_r;
  rot_t               d_nxt;
  logic signed [33:0] xi;
  logic signed [33:0] yi;
  logic signed [33:0] zi;
  logic signed [33:0] atan_c;

  assign xi     = d_in.x;
  assign yi     = d_in.y;
  assign zi     = d_in.z;
  assign atan_c = atan_q30(IDX);
  assign rdy_up = !v_r || rdy_dn;
  assign v_out  = v_r;
  assign d_out  = d_r;

  // Rotate toward zero residual angle; shifts floor toward minus infinity
  always_comb begin
    d_nxt = d_in;
    if (!zi[33]) begin
      d_nxt.x = xi - (yi >>> IDX);
      d_nxt.y = yi + (xi >>> IDX);
      d_nxt.z = zi - atan_c;
    end else begin
      d_nxt.x = xi + (yi >>> IDX);
      d_nxt.y = yi - (xi >>> IDX);
      d_nxt.z = zi + atan_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy_up) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_up && v_in) begin
      d_r <= d_nxt;
    end
  end

endmodule

[rtl/core/lbg_front.sv]
// Beam qualification, angle build, range reduction and quadrant fold.
module lbg_front (
  input  logic           clk,
  input  logic           rst_n,
  input  lbg_pkg::cfg_t  cfg,
  input  logic           v_in,
  input  lbg_pkg::beam_t b_in,
  output logic           rdy_up,
  output logic           v_out,
  output lbg_pkg::rot_t  d_out,
  input  logic           rdy_dn
);
  import lbg_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  logic               rej1_r, rej2_r, rej3_r;
  logic [31:0]        rng1_r, rng2_r, rng3_r;
  logic [31:0]        prod1_r;
  logic signed [33:0] z2_r, z3_r;
  rot_t               d4_r;

  logic               rej_c;
  logic [31:0]        ang_c;
  logic signed [33:0] z3_nxt;
  rot_t               d4_nxt;

  assign rdy4   = !v4_r || rdy_dn;
  assign rdy3   = !v3_r || rdy4;
  assign rdy2   = !v2_r || rdy3;
  assign rdy1   = !v1_r || rdy2;
  assign rdy_up = rdy1;
  assign v_out  = v4_r;
  assign d_out  = d4_r;

  assign rej_c = !b_in.range_valid
              || (32'(b_in.beam_index) >= MAX_BEAMS)
              || (b_in.beam_range > cfg.win_max)
              || (b_in.beam_range < cfg.win_min);

  assign ang_c = cfg.angle_start + prod1_r;

  // One step of 2*pi brings any Q4.30 angle into (-pi, pi]
  always_comb begin
    priority if (z2_r > Q30_PI) begin
      z3_nxt = z2_r - Q30_TWO_PI;
    end else if (z2_r <= -Q30_PI) begin
      z3_nxt = z2_r + Q30_TWO_PI;
    end else begin
      z3_nxt = z2_r;
    end
  end

  // Fold into +-pi/2 and mark the result for negation
  always_comb begin
    d4_nxt.rej  = rej3_r;
    d4_nxt.rng  = rng3_r;
    d4_nxt.x    = Q30_GAIN;
    d4_nxt.y    = '0;
    d4_nxt.flip = 1'b0;
    d4_nxt.z    = z3_r;
    priority if (z3_r > Q30_HALF_PI) begin
      d4_nxt.z    = z3_r - Q30_PI;
      d4_nxt.flip = 1'b1;
    end else if (z3_r < -Q30_HALF_PI) begin
      d4_nxt.z    = z3_r + Q30_PI;
      d4_nxt.flip = 1'b1;
    end else begin
      d4_nxt.flip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= v_in;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && v_in) begin
      rej1_r  <= rej_c;
      rng1_r  <= b_in.beam_range;
      prod1_r <= 32'(32'(b_in.beam_index) * cfg.angle_step);
    end
    if (rdy2 && v1_r) begin
      rej2_r <= rej1_r;
      rng2_r <= rng1_r;
      z2_r   <= $signed({ang_c, 2'b00});
    end
    if (rdy3 && v2_r) begin
      rej3_r <= rej2_r;
      rng3_r <= rng2_r;
      z3_r   <= z3_nxt;
    end
    if (rdy4 && v3_r) begin
      d4_r <= d4_nxt;
    end
  end

endmodule

[rtl/core/lbg_back.sv]
// Polar-to-map projection, truncation, bounds check and row-major index.
module lbg_back (
  input  logic           clk,
  input  logic           rst_n,
  input  lbg_pkg::cfg_t  cfg,
  input  logic           v_in,
  input  lbg_pkg::rot_t  d_in,
  output logic           rdy_up,
  output logic           v_out,
  output lbg_pkg::cell_t c_out,
  input  logic           rdy_dn
);
  import lbg_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic               rej1_r, rej2_r, rej3_r;
  logic signed [35:0] px1_r, py1_r;
  logic signed [51:0] mx0_r, mx1_r, my0_r, my1_r;
  logic signed [53:0] sx3_r, sy3_r;
  logic               hit4_r;
  logic [12:0]        cx4_r, cy4_r;
  cell_t              c5_r;

  logic signed [33:0] cos_c, sin_c;
  logic signed [66:0] prx_c, pry_c;
  logic signed [67:0] mx0_c, mx1_c, my0_c, my1_c;
  logic signed [53:0] sx_c, sy_c, xa_c, ya_c;
  logic signed [37:0] cxw_c, cyw_c;
  logic signed [37:0] w_s, h_s;
  logic               inb_c;
  logic [25:0]        idx_c;
  cell_t              c5_nxt;

  assign rdy5   = !v5_r || rdy_dn;
  assign rdy4   = !v4_r || rdy5;
  assign rdy3   = !v3_r || rdy4;
  assign rdy2   = !v2_r || rdy3;
  assign rdy1   = !v1_r || rdy2;
  assign rdy_up = rdy1;
  assign v_out  = v5_r;
  assign c_out  = c5_r;

  // Range times cosine and sine, floored back to Q16.16
  assign cos_c = d_in.flip ? -d_in.x : d_in.x;
  assign sin_c = d_in.flip ? -d_in.y : d_in.y;
  assign prx_c = $signed({1'b0, d_in.rng}) * cos_c;
  assign pry_c = $signed({1'b0, d_in.rng}) * sin_c;

  assign mx0_c = cfg.gain_x0 * px1_r;
  assign mx1_c = cfg.gain_x1 * py1_r;
  assign my0_c = cfg.gain_y0 * px1_r;
  assign my1_c = cfg.gain_y1 * py1_r;

  assign sx_c = 54'(mx0_r) + 54'(mx1_r) + 54'(cfg.off_x);
  assign sy_c = 54'(my0_r) + 54'(my1_r) + 54'(cfg.off_y);

  // Truncate toward zero: bias negatives by one cell less one lsb before the shift
  assign xa_c  = sx3_r + (sx3_r[53] ? 54'sd65535 : 54'sd0);
  assign ya_c  = sy3_r + (sy3_r[53] ? 54'sd65535 : 54'sd0);
  assign cxw_c = xa_c[53:16];
  assign cyw_c = ya_c[53:16];
  assign w_s   = $signed({25'd0, cfg.grid_w});
  assign h_s   = $signed({25'd0, cfg.grid_h});
  assign inb_c = !cxw_c[37] && (cxw_c < w_s) && !cyw_c[37] && (cyw_c < h_s);

  assign idx_c = 26'(cy4_r) * 26'(cfg.grid_w) + 26'(cx4_r);

  always_comb begin
    c5_nxt = '0;
    if (hit4_r) begin
      c5_nxt.hit        = 1'b1;
      c5_nxt.cell_x     = cx4_r[11:0];
      c5_nxt.cell_y     = cy4_r[11:0];
      c5_nxt.cell_index = idx_c[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= v_in;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && v_in) begin
      rej1_r <= d_in.rej;
      px1_r  <= prx_c[65:30];
      py1_r  <= pry_c[65:30];
    end
    if (rdy2 && v1_r) begin
      rej2_r <= rej1_r;
      mx0_r  <= mx0_c[67:16];
      mx1_r  <= mx1_c[67:16];
      my0_r  <= my0_c[67:16];
      my1_r  <= my1_c[67:16];
    end
    if (rdy3 && v2_r) begin
      rej3_r <= rej2_r;
      sx3_r  <= sx_c;
      sy3_r  <= sy_c;
    end
    if (rdy4 && v3_r) begin
      hit4_r <= !rej3_r && inb_c;
      cx4_r  <= cxw_c[12:0];
      cy4_r  <= cyw_c[12:0];
    end
    if (rdy5 && v4_r) begin
      c5_r <= c5_nxt;
    end
  end

endmodule

[rtl/core/laser_beam_to_grid_cell.sv]
// Top level: projects one lidar beam per item onto an occupancy-grid cell.
//
// Usage:
//   in_beam  : beam items (beam_index, beam_range Q16.16, range_valid).
//   out_cell : one result item per beam (hit, cell_x, cell_y, cell_index);
//              a rejected or off-map beam gives hit 0 and all fields 0.
//   cfg_wr   : register writes (index, data), always ready; write only while
//              no item is in flight.
// Throughput: one item per cycle, sustained while out_cell is not stalled.
// Pipeline: CORDIC_STAGES + 9 register stages
//   (4 front stages: window check and index times step, angle sum,
//   2*pi reduction, fold; one CORDIC cell per stage; 5 back stages: range
//   multiply, gain multiplies, sum, truncate and bounds check, row-major index).
// Each stage carries its own valid bit, so bubbles collapse: while out_cell
//   is stalled, new items are still taken until every stage is full, then
//   in_beam.ready drops. Results come out in input order.
// Reset (rst_n low, synchronous) empties the pipeline and loads the
//   register defaults: full range window, zero angles, zero transform,
//   4096 by 4096 map.
module laser_beam_to_grid_cell #(
  parameter int unsigned CORDIC_STAGES = 18
) (
  input  logic             clk,
  input  logic             rst_n,
  lbg_in_if.sink           in_beam,
  lbg_out_if.source        out_cell,
  lbg_cfg_if.sink          cfg_wr
);
  import lbg_pkg::*;

  localparam int unsigned DEPTH   = CORDIC_STAGES + 9;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

  // Configuration registers
  logic [63:0] range_window_r;
  logic [31:0] angle_start_r;
  logic [31:0] angle_step_r;
  logic [12:0] grid_width_r;
  logic [12:0] grid_height_r;
  logic [63:0] row_x_gains_r;
  logic [63:0] row_y_gains_r;
  logic [63:0] cell_offsets_r;

  cfg_t  cfg;
  beam_t beam;
  cell_t res_cell;

  logic  fr_v, fr_rdy;
  rot_t  fr_d;
  logic  bk_rdy;

  logic  v_c   [CORDIC_STAGES+1];
  rot_t  d_c   [CORDIC_STAGES+1];
  logic  rdy_c [CORDIC_STAGES+1];

  logic [CNT_W-1:0] inflight_r;
  logic [CNT_W-1:0] inflight_nxt;
  logic             in_acc, out_acc;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_window_r <= 64'hFFFF_FFFF_0000_0000;
      angle_start_r  <= '0;
      angle_step_r   <= '0;
      grid_width_r   <= 13'd4096;
      grid_height_r  <= 13'd4096;
      row_x_gains_r  <= '0;
      row_y_gains_r  <= '0;
      cell_offsets_r <= '0;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      unique case (cfg_wr.index)
        REG_RANGE_WINDOW: range_window_r <= cfg_wr.data;
        REG_ANGLE_START:  angle_start_r  <= cfg_wr.data[31:0];
        REG_ANGLE_STEP:   angle_step_r   <= cfg_wr.data[31:0];
        REG_GRID_WIDTH:   grid_width_r   <= cfg_wr.data[12:0];
        REG_GRID_HEIGHT:  grid_height_r  <= cfg_wr.data[12:0];
        REG_ROW_X_GAINS:  row_x_gains_r  <= cfg_wr.data;
        REG_ROW_Y_GAINS:  row_y_gains_r  <= cfg_wr.data;
        REG_CELL_OFFSETS: cell_offsets_r <= cfg_wr.data;
        default: ; // drop writes to unknown registers
      endcase
    end
  end

  // Unpack the registers; clamp oversized map dimensions
  always_comb begin
    cfg.win_min     = range_window_r[31:0];
    cfg.win_max     = range_window_r[63:32];
    cfg.angle_start = angle_start_r;
    cfg.angle_step  = angle_step_r;
    cfg.grid_w      = (32'(grid_width_r) > MAX_GRID_DIM) ? 13'(MAX_GRID_DIM) : grid_width_r;
    cfg.grid_h      = (32'(grid_height_r) > MAX_GRID_DIM) ? 13'(MAX_GRID_DIM)
                                                           : grid_height_r;
    cfg.gain_x0     = row_x_gains_r[31:0];
    cfg.gain_x1     = row_x_gains_r[63:32];
    cfg.gain_y0     = row_y_gains_r[31:0];
    cfg.gain_y1     = row_y_gains_r[63:32];
    cfg.off_x       = cell_offsets_r[31:0];
    cfg.off_y       = cell_offsets_r[63:32];
  end

  assign beam.range_valid = in_beam.range_valid;
  assign beam.beam_range  = in_beam.beam_range;
  assign beam.beam_index  = in_beam.beam_index;
  assign in_beam.ready    = fr_rdy;

  lbg_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .v_in   (in_beam.valid),
    .b_in   (beam),
    .rdy_up (fr_rdy),
    .v_out  (fr_v),
    .d_out  (fr_d),
    .rdy_dn (rdy_c[0])
  );

  assign v_c[0] = fr_v;
  assign d_c[0] = fr_d;

  // Rotation chain: cell i applies micro-rotation i and hands on to cell i+1
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    lbg_cordic_cell #(.IDX(i)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .v_in   (v_c[i]),
      .d_in   (d_c[i]),
      .rdy_up (rdy_c[i]),
      .v_out  (v_c[i+1]),
      .d_out  (d_c[i+1]),
      .rdy_dn (rdy_c[i+1])
    );
  end

  assign rdy_c[CORDIC_STAGES] = bk_rdy;

  lbg_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .v_in   (v_c[CORDIC_STAGES]),
    .d_in   (d_c[CORDIC_STAGES]),
    .rdy_up (bk_rdy),
    .v_out  (out_cell.valid),
    .c_out  (res_cell),
    .rdy_dn (out_cell.ready)
  );

  assign out_cell.hit        = res_cell.hit;
  assign out_cell.cell_x     = res_cell.cell_x;
  assign out_cell.cell_y     = res_cell.cell_y;
  assign out_cell.cell_index = res_cell.cell_index;

  // Track items in flight for the checks below
  assign in_acc  = in_beam.valid && in_beam.ready;
  assign out_acc = out_cell.valid && out_cell.ready;

  always_comb begin
    inflight_nxt = inflight_r;
    if (in_acc && !out_acc) begin
      inflight_nxt = inflight_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      inflight_nxt = inflight_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_cell.valid && !out_cell.hit |->
      out_cell.cell_x == '0 && out_cell.cell_y == '0 && out_cell.cell_index == '0)
    else $error("miss result carries nonzero cell fields");

  a_depth : assert property (@(posedge clk) disable iff (!rst_n)
    32'(inflight_r) <= DEPTH)
    else $error("more items in flight than pipeline stages");

  a_no_phantom : assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r == '0 |-> !out_cell.valid)
    else $error("result offered with no item in flight");

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_cell.valid && inflight_r == '0)
    else $error("pipeline not empty after reset");

endmodule
